[rtl/ksss_pkg.sv]
`timescale 1ns / 1ps

package ksss_pkg;

    localparam int STORE_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int BOUND_W         = 4;

    typedef enum logic [0:0] {
        ST_ACCEPT = 1'b0,
        ST_DRAIN  = 1'b1
    } sorter_state_t;

    // control broadcast to every cell of the sorted row
    typedef struct packed {
        logic                       take;   // row moves one place toward cell 0
        logic                       ins;    // new value goes into its sorted place
        logic signed [VALUE_W-1:0]  key;
    } cell_ctl_t;

endpackage

[rtl/ksss_item_if.sv]
`timescale 1ns / 1ps

interface ksss_item_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [ksss_pkg::VALUE_W-1:0]    value;
    logic                                   is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);

endinterface

[rtl/ksss_result_if.sv]
`timescale 1ns / 1ps

interface ksss_result_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [ksss_pkg::VALUE_W-1:0]    sorted_value;
    logic                                   is_final;

    modport source (output valid, output sorted_value, output is_final, input ready);
    modport sink   (input valid, input sorted_value, input is_final, output ready);

endinterface

[rtl/ksss_cell.sv]
`timescale 1ns / 1ps

module ksss_cell
(
    input  logic                                    clk,
    input  ksss_pkg::cell_ctl_t                     ctl,
    input  logic signed [ksss_pkg::VALUE_W-1:0]     left_val,
    input  logic signed [ksss_pkg::VALUE_W-1:0]     right_val,
    input  logic                                    own_sv,
    input  logic                                    left_sv,
    output logic signed [ksss_pkg::VALUE_W-1:0]     val
);

    logic signed [ksss_pkg::VALUE_W-1:0] val_reg;
    logic signed [ksss_pkg::VALUE_W-1:0] val_next;
    logic signed [ksss_pkg::VALUE_W-1:0] s_own;
    logic signed [ksss_pkg::VALUE_W-1:0] s_left;

    // row contents after the optional removal of the minimum
    assign s_own  = ctl.take ? right_val : val_reg;
    assign s_left = ctl.take ? val_reg   : left_val;

    always_comb
    begin
        val_next = s_own;
        if (ctl.ins)
        begin
            if (own_sv && (s_own <= ctl.key))
            begin
                val_next = s_own;
            end
            else if (left_sv && (s_left > ctl.key))
            begin
                val_next = s_left;
            end
            else
            begin
                val_next = ctl.key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

[rtl/k_sorted_stream_sorter.sv]
`timescale 1ns / 1ps

// k-sorted stream sorter: sorts a stream of signed 32-bit items in which each
// item lies at most k = displacement_bound places from its sorted position.
// The values are kept in ascending order in a row of STORE_DEPTH cells; each
// cell compares the incoming item with its own and its left neighbor's value,
// so the minimum is removed and the new item inserted in the same cycle.
// While fewer than min(k+1, STORE_DEPTH) values are held an item is only
// stored; after that each item first emits the current minimum. An item with
// is_last set does the same and then the whole row drains in ascending order,
// the final result flagged with is_final. Rate: one item per cycle while the
// single output register keeps being taken; an item marked last is followed
// by a drain of every held value (at most STORE_DEPTH), during which no
// item is taken. displacement_bound may be written only while idle.
module k_sorted_stream_sorter
#(
    parameter int STORE_DEPTH = ksss_pkg::STORE_DEPTH_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ksss_pkg::BOUND_W-1:0]        cfg_wdata,
    ksss_item_if.sink                           items,
    ksss_result_if.source                       results
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int TW = ksss_pkg::BOUND_W + 1;
    localparam int WW = (CW > TW) ? CW : TW;

    ksss_pkg::sorter_state_t                state_reg;
    ksss_pkg::sorter_state_t                state_next;
    logic [CW-1:0]                          count_reg;
    logic [CW-1:0]                          count_next;
    logic [ksss_pkg::BOUND_W-1:0]           bound_reg;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic signed [ksss_pkg::VALUE_W-1:0]    out_value_reg;
    logic signed [ksss_pkg::VALUE_W-1:0]    out_value_next;
    logic                                   out_final_reg;
    logic                                   out_final_next;

    logic                                   slot_free;
    logic                                   accept;
    logic                                   at_threshold;
    logic [TW-1:0]                          threshold;
    logic [CW-1:0]                          count_shifted;
    ksss_pkg::cell_ctl_t                    ctl;

    // cell values and their valid flags, one per cell of the row
    logic signed [ksss_pkg::VALUE_W-1:0]    row_val [STORE_DEPTH];
    logic [STORE_DEPTH-1:0]                 row_sv;

    // output register frees when empty or being taken this cycle
    assign slot_free = !out_valid_reg || results.ready;
    assign items.ready = (state_reg == ksss_pkg::ST_ACCEPT) && slot_free;
    assign accept = items.valid && items.ready;

    // fill threshold is min(k+1, STORE_DEPTH); count never exceeds STORE_DEPTH
    assign threshold = {1'b0, bound_reg} + TW'(1);
    assign at_threshold = (WW'(count_reg) >= WW'(threshold))
                       || (count_reg == CW'(STORE_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;
        ctl.take       = 1'b0;
        ctl.ins        = 1'b0;
        ctl.key        = items.value;

        case (state_reg)
            ksss_pkg::ST_ACCEPT:
            begin
                if (accept)
                begin
                    ctl.ins  = 1'b1;
                    ctl.take = at_threshold;
                    if (at_threshold)
                    begin
                        // steady state: emit minimum, count unchanged
                        out_valid_next = 1'b1;
                        out_value_next = row_val[0];
                        out_final_next = 1'b0;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    if (items.is_last)
                    begin
                        state_next = ksss_pkg::ST_DRAIN;
                    end
                end
            end
            ksss_pkg::ST_DRAIN:
            begin
                if (slot_free)
                begin
                    ctl.take       = 1'b1;
                    out_valid_next = 1'b1;
                    out_value_next = row_val[0];
                    out_final_next = (count_reg == CW'(1));
                    count_next     = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        state_next = ksss_pkg::ST_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = ksss_pkg::ST_ACCEPT;
            end
        endcase
    end

    // number of valid values once the minimum has been taken out
    assign count_shifted = count_reg - CW'(ctl.take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ksss_pkg::ST_ACCEPT;
            count_reg     <= '0;
            bound_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                bound_reg <= cfg_wdata;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_final_reg <= out_final_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.is_final     = out_final_reg;

    // sorted row of cells, cell 0 holds the minimum
    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        assign row_sv[i] = (CW'(i) < count_shifted);

        if (i == 0)
        begin : g_first
            ksss_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .left_val  (row_val[0]),
                .right_val (row_val[1]),
                .own_sv    (row_sv[0]),
                .left_sv   (1'b0),
                .val       (row_val[0])
            );
        end
        else if (i == STORE_DEPTH - 1)
        begin : g_last
            ksss_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .left_val  (row_val[i-1]),
                .right_val (row_val[i]),
                .own_sv    (row_sv[i]),
                .left_sv   (row_sv[i-1]),
                .val       (row_val[i])
            );
        end
        else
        begin : g_mid
            ksss_cell u_cell
            (
                .clk       (clk),
                .ctl       (ctl),
                .left_val  (row_val[i-1]),
                .right_val (row_val[i+1]),
                .own_sv    (row_sv[i]),
                .left_sv   (row_sv[i-1]),
                .val       (row_val[i])
            );
        end
    end

endmodule
